### rtl/mzc_pkg.sv
// Shared types, constants and the control store of the MPE zone sequencer.
`timescale 1ns / 1ps

package mzc_pkg;

  // Field widths
  localparam int STEP_W   = 7;
  localparam int CNT_W    = 7;
  localparam int UPC_W    = 4;
  localparam int MEMBER_W = 4;

  // Request limits and message constants
  localparam logic [CNT_W-1:0] MAX_BUDGET   = 7'd64;
  localparam logic [7:0]       STATUS_CC    = 8'hB0;
  localparam logic [3:0]       MGR_CH_LOWER = 4'd0;
  localparam logic [3:0]       MGR_CH_UPPER = 4'd15;
  localparam logic [3:0]       MEMBER_TOP   = 4'd14;
  localparam logic [3:0]       MEMBER_MAX   = 4'd14;

  // Controller numbers
  localparam logic [6:0] CC_RPN_MSB  = 7'd101;
  localparam logic [6:0] CC_RPN_LSB  = 7'd100;
  localparam logic [6:0] CC_DATA_MSB = 7'd6;
  localparam logic [6:0] CC_DATA_LSB = 7'd38;

  // Outcome codes
  localparam logic [1:0] OC_OK         = 2'd0;
  localparam logic [1:0] OC_BAD_BUDGET = 2'd1;
  localparam logic [1:0] OC_REFUSED    = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_ZONE_UPPER   = 2'd0;
  localparam logic [1:0] REG_MEMBER_COUNT = 2'd1;
  localparam logic [1:0] REG_BEND_RANGE   = 2'd2;

  // First control-store address of the per-member group
  localparam logic [UPC_W-1:0] UPC_MEMBER_START = 4'd3;

  // Value byte selection
  typedef enum logic [2:0] {
    VS_ZERO,
    VS_SIX,
    VS_COUNT,
    VS_BEND,
    VS_FULL
  } vsel_t;

  // One control word: controller, value source, channel source, group wrap
  typedef struct packed {
    logic [6:0] ctl;
    vsel_t      vsel;
    logic       mgr;
    logic       wrap;
  } uword_t;

  typedef struct packed {
    logic       zone_upper;
    logic [3:0] member_count;
    logic [6:0] pb_range;
  } cfg_t;

  // Control store: configuration message, then the member RPN group
  function automatic uword_t ucode_word(input logic [UPC_W-1:0] upc);
    uword_t w;
    w = '{ctl: CC_RPN_MSB, vsel: VS_ZERO, mgr: 1'b0, wrap: 1'b1};
    unique case (upc)
      4'd0:    w = '{ctl: CC_RPN_MSB,  vsel: VS_ZERO,  mgr: 1'b1, wrap: 1'b0};
      4'd1:    w = '{ctl: CC_RPN_LSB,  vsel: VS_SIX,   mgr: 1'b1, wrap: 1'b0};
      4'd2:    w = '{ctl: CC_DATA_MSB, vsel: VS_COUNT, mgr: 1'b1, wrap: 1'b0};
      4'd3:    w = '{ctl: CC_RPN_MSB,  vsel: VS_ZERO,  mgr: 1'b0, wrap: 1'b0};
      4'd4:    w = '{ctl: CC_RPN_LSB,  vsel: VS_ZERO,  mgr: 1'b0, wrap: 1'b0};
      4'd5:    w = '{ctl: CC_DATA_MSB, vsel: VS_BEND,  mgr: 1'b0, wrap: 1'b0};
      4'd6:    w = '{ctl: CC_DATA_LSB, vsel: VS_ZERO,  mgr: 1'b0, wrap: 1'b0};
      4'd7:    w = '{ctl: CC_RPN_MSB,  vsel: VS_FULL,  mgr: 1'b0, wrap: 1'b0};
      4'd8:    w = '{ctl: CC_RPN_LSB,  vsel: VS_FULL,  mgr: 1'b0, wrap: 1'b1};
      default: w = '{ctl: CC_RPN_MSB,  vsel: VS_ZERO,  mgr: 1'b0, wrap: 1'b1};
    endcase
    return w;
  endfunction

endpackage

### rtl/mzc_if.sv
// Valid/ready channel interfaces for requests and message results.
`timescale 1ns / 1ps

interface mzc_req_if;
  logic       valid;
  logic       ready;
  logic [6:0] budget;
  logic [6:0] sink_room;

  modport source (output valid, budget, sink_room, input ready);
  modport sink   (input valid, budget, sink_room, output ready);
endinterface

interface mzc_rsp_if;
  logic       valid;
  logic       ready;
  logic       msg_valid;
  logic [7:0] status_byte;
  logic [6:0] controller;
  logic [6:0] ctl_value;
  logic       last;
  logic [6:0] sent_count;
  logic [1:0] outcome;
  logic       configured;

  modport source (output valid, msg_valid, status_byte, controller, ctl_value, last,
                  sent_count, outcome, configured, input ready);
  modport sink   (input valid, msg_valid, status_byte, controller, ctl_value, last,
                  sent_count, outcome, configured, output ready);
endinterface

### rtl/mzc_useq.sv
// Microcode step counter, member counter and script position.
`timescale 1ns / 1ps

module mzc_useq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  output logic [mzc_pkg::STEP_W-1:0]    script_step,
  output logic [mzc_pkg::MEMBER_W-1:0]  member_idx,
  output mzc_pkg::uword_t               uword
);
  import mzc_pkg::*;

  logic [UPC_W-1:0] upc;

  // Fetch the control word of the current step
  assign uword = ucode_word(upc);

  // Advance one script step; wrap the member group back to its start
  always_ff @(posedge clk) begin
    if (rst) begin
      upc         <= '0;
      member_idx  <= '0;
      script_step <= '0;
    end else if (advance) begin
      script_step <= script_step + STEP_W'(1);
      if (uword.wrap) begin
        upc        <= UPC_MEMBER_START;
        member_idx <= member_idx + MEMBER_W'(1);
      end else begin
        upc <= upc + UPC_W'(1);
      end
    end
  end

endmodule

### rtl/mzc_msg_gen.sv
// Message datapath: channel and value byte from the control word.
`timescale 1ns / 1ps

module mzc_msg_gen (
  input  mzc_pkg::uword_t               uword,
  input  mzc_pkg::cfg_t                 cfg,
  input  logic [mzc_pkg::MEMBER_W-1:0]  member_idx,
  output logic [7:0]                    status_byte,
  output logic [6:0]                    controller,
  output logic [6:0]                    ctl_value
);
  import mzc_pkg::*;

  logic [3:0] member_cl;
  logic [3:0] channel;

  // Pick the channel: manager, or member counting up or down
  always_comb begin
    member_cl = (member_idx > MEMBER_MAX) ? MEMBER_MAX : member_idx;
    if (uword.mgr) begin
      channel = cfg.zone_upper ? MGR_CH_UPPER : MGR_CH_LOWER;
    end else if (cfg.zone_upper) begin
      channel = MEMBER_TOP - member_cl;
    end else begin
      channel = member_idx + 4'd1;
    end
  end

  assign status_byte = STATUS_CC + {4'd0, channel};
  assign controller  = uword.ctl;

  // Select the value byte
  always_comb begin
    case (uword.vsel)
      VS_SIX:   ctl_value = 7'd6;
      VS_COUNT: ctl_value = {3'd0, cfg.member_count};
      VS_BEND:  ctl_value = cfg.pb_range;
      VS_FULL:  ctl_value = 7'd127;
      default:  ctl_value = 7'd0;
    endcase
  end

endmodule

### rtl/mpe_zone_config_sequencer.sv
// Top level of the MPE zone sequencer: registers, request control, result register.
//
//  channel  dir  handshake       payload
//  req      in   valid/ready     budget, sink_room
//  rsp      out  valid/ready     msg_valid, status_byte, controller, ctl_value,
//                                last, sent_count, outcome, configured
//  apb      in   psel/penable    paddr, pwdata, prdata (pready tied high)
//
// A request that sends nothing still returns one empty result. Messages leave
// one per cycle while the result register is free, one control-store step per
// sent message. Reset is synchronous and needs no clearing pass.
// A stalled result holds the sequencer; the next request is taken once the
// last result of the current one is in the result register.
`timescale 1ns / 1ps

module mpe_zone_config_sequencer (
  input  logic        clk,
  input  logic        rst,
  mzc_req_if.sink     req,
  mzc_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mzc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                state;
  cfg_t                cfg;
  logic [CNT_W-1:0]    budget;
  logic [CNT_W-1:0]    room;
  logic [CNT_W-1:0]    sent;
  logic [CNT_W-1:0]    sent_next;
  logic [STEP_W-1:0]   script_step;
  logic [STEP_W-1:0]   step_next;
  logic [STEP_W-1:0]   total;
  logic [MEMBER_W-1:0] member_idx;
  uword_t              uword;
  logic [7:0]          gen_status;
  logic [6:0]          gen_ctl;
  logic [6:0]          gen_value;
  logic                slot_free;
  logic                emit;
  logic                finish;
  logic                last_msg;
  logic                done;
  logic                can_send;
  logic                wr_en;

  // Configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zone_upper   <= 1'b0;
      cfg.member_count <= 4'd2;
      cfg.pb_range     <= 7'd48;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_ZONE_UPPER:   cfg.zone_upper <= pwdata[0];
        REG_MEMBER_COUNT: cfg.member_count <=
                            (pwdata[3:0] > MEMBER_MAX) ? MEMBER_MAX : pwdata[3:0];
        REG_BEND_RANGE:   cfg.pb_range <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ZONE_UPPER:   prdata = {31'd0, cfg.zone_upper};
      REG_MEMBER_COUNT: prdata = {28'd0, cfg.member_count};
      REG_BEND_RANGE:   prdata = {25'd0, cfg.pb_range};
      default:          prdata = '0;
    endcase
  end

  // Sequencer and message datapath
  mzc_useq u_useq (
    .clk         (clk),
    .rst         (rst),
    .advance     (emit),
    .script_step (script_step),
    .member_idx  (member_idx),
    .uword       (uword)
  );

  mzc_msg_gen u_gen (
    .uword       (uword),
    .cfg         (cfg),
    .member_idx  (member_idx),
    .status_byte (gen_status),
    .controller  (gen_ctl),
    .ctl_value   (gen_value)
  );

  // Script length is three plus six per member
  assign total = STEP_W'({cfg.member_count, 2'b00}) + STEP_W'({cfg.member_count, 1'b0})
                 + STEP_W'(3);

  // Request control
  assign slot_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);
  assign done      = (script_step >= total);
  assign can_send  = (budget != '0) && (sent < budget) && !done && (sent < room);
  assign emit      = (state == ST_RUN) && slot_free && can_send;
  assign sent_next = sent + CNT_W'(1);
  assign step_next = script_step + STEP_W'(1);
  assign last_msg  = (sent_next >= budget) || (step_next >= total) || (sent_next >= room);
  assign finish    = (state == ST_RUN) && slot_free && (!can_send || last_msg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (req.valid) state <= ST_RUN;
        ST_RUN:  if (finish) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Latch the request, saturating the budget
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      budget <= (req.budget > MAX_BUDGET) ? MAX_BUDGET : req.budget;
      room   <= req.sink_room;
      sent   <= '0;
    end else if (emit) begin
      sent <= sent_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (slot_free) begin
      rsp.valid <= (state == ST_RUN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RUN && slot_free) begin
      if (can_send) begin
        rsp.msg_valid   <= 1'b1;
        rsp.status_byte <= gen_status;
        rsp.controller  <= gen_ctl;
        rsp.ctl_value   <= gen_value;
        rsp.last        <= last_msg;
        rsp.sent_count  <= last_msg ? sent_next : '0;
        rsp.outcome     <= OC_OK;
        rsp.configured  <= (step_next >= total);
      end else begin
        rsp.msg_valid   <= 1'b0;
        rsp.status_byte <= '0;
        rsp.controller  <= '0;
        rsp.ctl_value   <= '0;
        rsp.last        <= 1'b1;
        rsp.sent_count  <= '0;
        rsp.configured  <= done;
        if (budget == '0) begin
          rsp.outcome <= OC_BAD_BUDGET;
        end else if (!done && (room == '0)) begin
          rsp.outcome <= OC_REFUSED;
        end else begin
          rsp.outcome <= OC_OK;
        end
      end
    end
  end

`ifndef SYNTH
  // Every sent message moves the script on by exactly one step
  a_step_advance: assert property (@(posedge clk) disable iff (rst)
    emit |=> (script_step == $past(script_step) + 7'd1))
    else $error("script step did not advance with a sent message");

  // A result without a message always closes its request
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.msg_valid) |-> rsp.last)
    else $error("empty result not marked last");

  // A running request never ends before its final result
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && !finish) |=> (state == ST_RUN))
    else $error("request ended without a final result");
`endif

endmodule
